// ----- rtl/api_frame_receive_parser_core_defines.svh -----
// Assertion macros shared by the frame receive parser RTL.
`ifndef API_FRAME_RECEIVE_PARSER_CORE_DEFINES_SVH
`define API_FRAME_RECEIVE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AFRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/afrp_pkg.sv -----
// Types and constants of the frame receive parser.
`default_nettype none

package afrp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER     = 2'd0,
        KIND_TX_STATUS = 2'd1,
        KIND_RX_PACKET = 2'd2
    } t_kind;

    typedef enum logic {
        OP_RX_BYTE = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    localparam logic [7:0]  START_BYTE     = 8'h7E;
    localparam logic [7:0]  TYPE_TX_STATUS = 8'h8B;
    localparam logic [7:0]  TYPE_RX_PACKET = 8'h90;
    localparam logic [7:0]  CSUM_BASE      = 8'hFF;
    localparam logic [7:0]  PLEN_MAX       = 8'hFF;
    localparam logic [15:0] TX_HDR_LEN     = 16'd7;
    localparam logic [15:0] RX_HDR_LEN     = 16'd12;

    // Fixed header positions inside the frame data
    localparam logic [15:0] POS_TYPE      = 16'd0;
    localparam logic [15:0] POS_FRAME_ID  = 16'd1;
    localparam logic [15:0] POS_DELIVERY  = 16'd5;
    localparam logic [15:0] POS_DISCOVERY = 16'd6;
    localparam logic [15:0] POS_SRC_FIRST = 16'd1;
    localparam logic [15:0] POS_OPTIONS   = 16'd11;

endpackage

`default_nettype wire

// ----- rtl/afrp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module afrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/api_frame_receive_parser_core.sv -----
// Top level of the start/length/checksum API frame receive parser.
//
// Input channel (i_s_*): one item per received serial byte (tuser = 0) or per
// read of a stored frame byte (tuser = 1). tdata carries the serial byte in
// [7:0] and the read position in [15:8].
// Output channel (o_m_*): exactly one result item per input item, in order.
// tlast flags a byte that closed a frame with a good checksum, tuser gives
// the frame kind, tdata the decoded header fields and the read byte.
// Timing: the result of an item is offered in the cycle after it is accepted.
// Throughput: one item per cycle while the output register is not stalled; the parser
// step, the frame buffer write and the header decode all sit between the input
// handshake and the output register, and the buffer read is registered beside it.
// Stall: the output register holds its item while i_m_tready is low, and
// o_s_tready drops only while that register is full and not being taken.
// Reset (i_rst_n low, synchronous): the parser returns to hunting for the
// start byte and the output register empties. The frame buffer is not
// cleared; reading a position not written since power-up gives undefined data.
// Header bytes are captured into registers as they arrive, so a completed
// frame decodes without touching the buffer.
`default_nettype none

`include "api_frame_receive_parser_core_defines.svh"

module api_frame_receive_parser_core #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input item
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [15:0]  i_s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  wire logic         i_s_tuser,   // op
    // result item
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // frame_type[7:0], status_frame_id[15:8], delivery_code[23:16],
    // discovery_code[31:24], source_address[95:32], receive_options[103:96],
    // payload_length[111:104], read_byte[119:112]
    output logic      [119:0] o_m_tdata,
    output logic      [1:0]   o_m_tuser,   // frame_kind
    output logic              o_m_tlast    // frame_done
);

    import afrp_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int IW = (AW > 8) ? AW : 8;
    localparam logic [16:0] MAX_FRAME_W = 17'(MAX_FRAME);

    // ---------------------------------------------------------------
    // Input handshake and field split
    // ---------------------------------------------------------------
    logic       w_in_acc;
    logic       w_rx_acc;
    logic       w_rd_acc;
    logic [7:0] w_rx_byte;
    logic [7:0] w_rd_index;
    t_op        w_op;

    assign w_op       = t_op'(i_s_tuser);
    assign w_rx_byte  = i_s_tdata[7:0];
    assign w_rd_index = i_s_tdata[15:8];
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_rx_acc   = w_in_acc && (w_op == OP_RX_BYTE);
    assign w_rd_acc   = w_in_acc && (w_op == OP_READ);

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    t_phase      r_phase,    n_phase;
    logic [15:0] r_exp_len,  n_exp_len;
    logic [15:0] r_byte_pos, n_byte_pos;
    logic [7:0]  r_sum,      n_sum;

    // Header bytes captured as they are written to the buffer
    logic [7:0] r_hdr_type;
    logic [7:0] r_hdr_src [8];   // frame bytes 1..8, byte 1 first
    logic [7:0] r_hdr_opt;

    logic [15:0] w_len_full;
    logic [15:0] w_pos_inc;
    logic        w_pos_in_range;

    assign w_len_full     = {r_exp_len[15:8], w_rx_byte};
    assign w_pos_inc      = r_byte_pos + 16'd1;
    assign w_pos_in_range = {1'b0, r_byte_pos} < MAX_FRAME_W;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_exp_len  = r_exp_len;
        n_byte_pos = r_byte_pos;
        n_sum      = r_sum;
        if (w_rx_acc) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_exp_len = {w_rx_byte, 8'h00};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_exp_len = w_len_full;
                    // drop empty or oversized frames back to hunting
                    if ((w_len_full == 16'd0) || ({1'b0, w_len_full} > MAX_FRAME_W)) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_byte_pos = 16'd0;
                        n_sum      = 8'd0;
                        n_phase    = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_byte_pos = w_pos_inc;
                    n_sum      = r_sum + w_rx_byte;
                    if (w_pos_inc >= r_exp_len) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    if (w_rx_byte == START_BYTE) begin
                        n_phase    = PH_LEN_HI;
                        n_exp_len  = 16'd0;
                        n_byte_pos = 16'd0;
                        n_sum      = 8'd0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_exp_len  <= 16'd0;
            r_byte_pos <= 16'd0;
            r_sum      <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_exp_len  <= n_exp_len;
            r_byte_pos <= n_byte_pos;
            r_sum      <= n_sum;
        end
    end

    logic w_data_wr;
    assign w_data_wr = w_rx_acc && (r_phase == PH_DATA);

    always_ff @(posedge i_clk) begin
        if (w_data_wr && (r_byte_pos == POS_TYPE)) begin
            r_hdr_type <= w_rx_byte;
        end
        if (w_data_wr && (r_byte_pos == POS_OPTIONS)) begin
            r_hdr_opt <= w_rx_byte;
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_src
        always_ff @(posedge i_clk) begin
            if (w_data_wr && (r_byte_pos == (POS_SRC_FIRST + 16'(k)))) begin
                r_hdr_src[k] <= w_rx_byte;
            end
        end
    end

    // ---------------------------------------------------------------
    // Frame buffer
    // ---------------------------------------------------------------
    logic [IW-1:0] w_rd_index_ext;
    logic [7:0]    w_ram_q;

    assign w_rd_index_ext = IW'(w_rd_index);

    afrp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_data_wr && w_pos_in_range),
        .i_wr_addr (r_byte_pos[AW-1:0]),
        .i_wr_data (w_rx_byte),
        .i_rd_en   (w_rd_acc),
        .i_rd_addr (w_rd_index_ext[AW-1:0]),
        .o_rd_data (w_ram_q)
    );

    // ---------------------------------------------------------------
    // Result decode
    // ---------------------------------------------------------------
    logic        w_done;
    t_kind       w_kind;
    logic [7:0]  w_type;
    logic [7:0]  w_fid;
    logic [7:0]  w_dlv;
    logic [7:0]  w_dsc;
    logic [63:0] w_src;
    logic [7:0]  w_opt;
    logic [7:0]  w_plen;
    logic [15:0] w_plen_full;
    logic        w_csum_ok;
    logic        w_rd_ok;

    assign w_plen_full = r_exp_len - RX_HDR_LEN;
    assign w_csum_ok   = (w_rx_byte == (CSUM_BASE - r_sum)) && (r_exp_len != 16'd0);
    assign w_rd_ok     = {9'd0, w_rd_index} < MAX_FRAME_W;

    always_comb begin
        w_done = 1'b0;
        w_kind = KIND_OTHER;
        w_type = 8'd0;
        w_fid  = 8'd0;
        w_dlv  = 8'd0;
        w_dsc  = 8'd0;
        w_src  = 64'd0;
        w_opt  = 8'd0;
        w_plen = 8'd0;
        if (w_op == OP_RX_BYTE && r_phase == PH_CSUM && w_csum_ok) begin
            w_done = 1'b1;
            w_type = r_hdr_type;
            if (r_hdr_type == TYPE_TX_STATUS && r_exp_len >= TX_HDR_LEN) begin
                w_kind = KIND_TX_STATUS;
                w_fid  = r_hdr_src[POS_FRAME_ID[2:0] - 3'd1];
                w_dlv  = r_hdr_src[POS_DELIVERY[2:0] - 3'd1];
                w_dsc  = r_hdr_src[POS_DISCOVERY[2:0] - 3'd1];
            end else if (r_hdr_type == TYPE_RX_PACKET && r_exp_len >= RX_HDR_LEN) begin
                w_kind = KIND_RX_PACKET;
                w_src  = {r_hdr_src[0], r_hdr_src[1], r_hdr_src[2], r_hdr_src[3],
                          r_hdr_src[4], r_hdr_src[5], r_hdr_src[6], r_hdr_src[7]};
                w_opt  = r_hdr_opt;
                // saturate for buffers longer than a byte-sized payload
                w_plen = (w_plen_full[15:8] != 8'd0) ? PLEN_MAX : w_plen_full[7:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic        r_out_valid, n_out_valid;
    logic        r_done;
    t_kind       r_kind;
    logic [7:0]  r_type;
    logic [7:0]  r_fid;
    logic [7:0]  r_dlv;
    logic [7:0]  r_dsc;
    logic [63:0] r_src;
    logic [7:0]  r_opt;
    logic [7:0]  r_plen;
    logic        r_is_read;
    logic        r_rd_ok;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign n_out_valid = w_in_acc || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_done    <= w_done;
            r_kind    <= w_kind;
            r_type    <= w_type;
            r_fid     <= w_fid;
            r_dlv     <= w_dlv;
            r_dsc     <= w_dsc;
            r_src     <= w_src;
            r_opt     <= w_opt;
            r_plen    <= w_plen;
            r_is_read <= (w_op == OP_READ);
            r_rd_ok   <= w_rd_ok;
        end
    end

    // RAM data holds until the next read, which cannot be accepted before
    // this item leaves the output register
    logic [7:0] w_read_byte;
    assign w_read_byte = (r_is_read && r_rd_ok) ? w_ram_q : 8'd0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_done;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = {w_read_byte, r_plen, r_opt, r_src, r_dsc, r_dlv, r_fid, r_type};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `AFRP_ASSERT_IMPL(a_read_no_frame, i_clk, i_rst_n,
        r_out_valid && r_is_read, !r_done && (r_kind == KIND_OTHER),
        "read item reports a frame")

    `AFRP_ASSERT_IMPL(a_kind_needs_done, i_clk, i_rst_n,
        r_out_valid && (r_kind != KIND_OTHER), r_done,
        "frame kind without a completed frame")

    `AFRP_ASSERT_IMPL(a_data_pos_bound, i_clk, i_rst_n,
        r_phase == PH_DATA, (r_byte_pos < r_exp_len) && ({1'b0, r_exp_len} <= MAX_FRAME_W),
        "data position past frame length")

    `AFRP_ASSERT_IMPL(a_csum_len, i_clk, i_rst_n,
        r_phase == PH_CSUM, (r_exp_len != 16'd0) && (r_byte_pos == r_exp_len),
        "checksum phase with inconsistent length")

    `AFRP_ASSERT_NEXT(a_read_keeps_state, i_clk, i_rst_n,
        w_rd_acc, $stable(r_phase) && $stable(r_byte_pos) && $stable(r_sum),
        "read item changed parser state")

endmodule

`default_nettype wire
